// ----- rtl/ovpf_pkg.sv -----
package ovpf_pkg;

  // Default structure of the octree walk
  localparam int unsigned MAX_DEPTH_DEF     = 8;
  localparam int unsigned FRACTION_BITS_DEF = 24;

  // Field widths
  localparam int unsigned COORD_W = 28;
  localparam int unsigned SIZE_W  = 21;
  localparam int unsigned NORM_W  = 18;
  localparam int unsigned FIELD_W = 25;
  localparam int unsigned DOT_W   = 64;
  localparam int unsigned PATH_W  = 4;

  localparam logic [PATH_W-1:0] CHILD_COUNT = 4'd8;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [FIELD_W-1:0] THRESHOLD_RESET = 25'd1678;
  localparam logic [ADDR_W-1:0]  ADDR_THRESHOLD  = 3'd0;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_EVAL = 6'b001000,
    ST_NEXT = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic eval;
    logic next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_empty;
    logic path_end;
  } status_t;

endpackage

// ----- rtl/ovpf_ctrl.sv -----
module ovpf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ovpf_pkg::status_t status_i,
  output ovpf_pkg::cmd_t    cmd_o
);

  ovpf_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             load;
  logic             finish;

  assign in_ready_o = (state_q == ovpf_pkg::ST_IDLE);
  assign load       = in_valid_i && in_ready_o;
  assign finish     = (state_q == ovpf_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // Sequence one voxel through set-up and the cell walk
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ovpf_pkg::ST_IDLE: begin
        if (load) state_d = ovpf_pkg::ST_MUL;
      end
      ovpf_pkg::ST_MUL:  state_d = ovpf_pkg::ST_SUM;
      ovpf_pkg::ST_SUM:  state_d = ovpf_pkg::ST_EVAL;
      ovpf_pkg::ST_EVAL: state_d = ovpf_pkg::ST_NEXT;
      ovpf_pkg::ST_NEXT: begin
        if (status_i.walk_empty) state_d = ovpf_pkg::ST_DONE;
        else if (!status_i.path_end) state_d = ovpf_pkg::ST_EVAL;
      end
      ovpf_pkg::ST_DONE: begin
        if (finish) state_d = ovpf_pkg::ST_IDLE;
      end
      default: state_d = ovpf_pkg::ST_IDLE;
    endcase
  end

  // Hold the result until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ovpf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = load;
    cmd_o.mul    = (state_q == ovpf_pkg::ST_MUL);
    cmd_o.sum    = (state_q == ovpf_pkg::ST_SUM);
    cmd_o.eval   = (state_q == ovpf_pkg::ST_EVAL);
    cmd_o.next   = (state_q == ovpf_pkg::ST_NEXT);
    cmd_o.finish = finish;
  end

endmodule

// ----- rtl/ovpf_datapath.sv -----
module ovpf_datapath #(
  parameter int unsigned MAX_DEPTH     = ovpf_pkg::MAX_DEPTH_DEF,
  parameter int unsigned FRACTION_BITS = ovpf_pkg::FRACTION_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  ovpf_pkg::cmd_t                           cmd_i,
  output ovpf_pkg::status_t                        status_o,
  input  logic        [ovpf_pkg::FIELD_W-1:0]      threshold_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0]      origin_x_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0]      origin_y_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0]      origin_z_i,
  input  logic        [ovpf_pkg::SIZE_W-1:0]       size_x_i,
  input  logic        [ovpf_pkg::SIZE_W-1:0]       size_y_i,
  input  logic        [ovpf_pkg::SIZE_W-1:0]       size_z_i,
  input  logic signed [ovpf_pkg::NORM_W-1:0]       normal_x_i,
  input  logic signed [ovpf_pkg::NORM_W-1:0]       normal_y_i,
  input  logic signed [ovpf_pkg::NORM_W-1:0]       normal_z_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0]      vertex_x_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0]      vertex_y_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0]      vertex_z_i,
  output logic        [ovpf_pkg::FIELD_W-1:0]      inside_fraction_o,
  output logic        [ovpf_pkg::FIELD_W-1:0]      error_bound_o,
  output logic                                     depth_capped_o
);

  localparam int unsigned DIFF_W = ovpf_pkg::COORD_W + 1;
  localparam int unsigned PD_W   = ovpf_pkg::NORM_W + DIFF_W;
  localparam int unsigned PS_W   = ovpf_pkg::NORM_W + ovpf_pkg::SIZE_W + 1;
  localparam int unsigned DOT_W  = ovpf_pkg::DOT_W;
  localparam int unsigned LVW    = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDXW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned ACC_W  = FRACTION_BITS + 1;
  localparam int unsigned CMP_W  = (ACC_W > ovpf_pkg::FIELD_W) ? ACC_W : ovpf_pkg::FIELD_W;
  localparam logic [ovpf_pkg::FIELD_W-1:0] FIELD_MAX = {ovpf_pkg::FIELD_W{1'b1}};

  // Operand registers
  logic signed [DIFF_W-1:0]            diff_q [3];
  logic signed [ovpf_pkg::NORM_W-1:0]  nrm_q  [3];
  logic        [ovpf_pkg::SIZE_W-1:0]  sz_q   [3];
  logic signed [PD_W-1:0]              pd_q   [3];
  logic signed [PS_W-1:0]              ps_q   [3];
  logic signed [DOT_W-1:0]             sub_q  [8];

  // Walk state
  logic signed [DOT_W-1:0]             cell_d0_q;
  logic        [LVW-1:0]               depth_q;
  logic        [LVW-1:0]               lv_q;
  logic        [ovpf_pkg::PATH_W-1:0]  path_q  [MAX_DEPTH];
  logic signed [DOT_W-1:0]             stack_q [MAX_DEPTH];
  logic        [ACC_W-1:0]             frac_q, err_q;
  logic                                capped_q;

  logic        [ovpf_pkg::FIELD_W-1:0] frac_out_q, err_out_q;
  logic                                capped_out_q;

  // Capture the corner offset from the surface point, the normal and the edge sizes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      diff_q[0] <= DIFF_W'(origin_x_i) - DIFF_W'(vertex_x_i);
      diff_q[1] <= DIFF_W'(origin_y_i) - DIFF_W'(vertex_y_i);
      diff_q[2] <= DIFF_W'(origin_z_i) - DIFF_W'(vertex_z_i);
      nrm_q[0]  <= normal_x_i;
      nrm_q[1]  <= normal_y_i;
      nrm_q[2]  <= normal_z_i;
      sz_q[0]   <= size_x_i;
      sz_q[1]   <= size_y_i;
      sz_q[2]   <= size_z_i;
    end
  end

  // Form normal times offset and normal times edge per axis
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int i = 0; i < 3; i++) begin
        pd_q[i] <= PD_W'(nrm_q[i]) * PD_W'(diff_q[i]);
        ps_q[i] <= PS_W'(nrm_q[i]) * PS_W'(signed'({1'b0, sz_q[i]}));
      end
    end
  end

  // Subset sums of the edge terms: corner c adds those axes set in c
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      for (int c = 0; c < 8; c++) begin
        sub_q[c] <= (c[0] ? DOT_W'(ps_q[0]) : '0)
                  + (c[1] ? DOT_W'(ps_q[1]) : '0)
                  + (c[2] ? DOT_W'(ps_q[2]) : '0);
      end
    end
  end

  // Cell classification
  logic        [LVW-1:0]   cell_shift;
  logic signed [DOT_W-1:0] corner [8];
  logic        [7:0]       corner_in;
  logic                    all_in, none_in;
  logic        [ACC_W-1:0] vol;
  logic                    below;
  logic                    at_cap;
  int                      vol_sh;

  assign cell_shift = LVW'(MAX_DEPTH) - depth_q;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      corner[c]    = cell_d0_q + (sub_q[c] <<< cell_shift);
      corner_in[c] = corner[c][DOT_W-1];
    end
  end

  assign all_in  = &corner_in;
  assign none_in = ~|corner_in;

  always_comb begin
    vol_sh = int'(FRACTION_BITS) - 3 * (int'(depth_q) - 1);
    if (vol_sh < 0) vol = '0;
    else vol = ACC_W'(1) << vol_sh;
  end

  assign below  = CMP_W'(vol) < CMP_W'(threshold_i);
  assign at_cap = (int'(depth_q) >= int'(MAX_DEPTH));

  // Child generation
  logic [LVW-1:0]              lv_m1;
  logic [IDXW-1:0]             lv_idx;
  logic [IDXW-1:0]             depth_idx;
  logic [ovpf_pkg::PATH_W-1:0] k;
  logic [LVW-1:0]              child_shift;

  assign lv_m1       = lv_q - 1'b1;
  assign lv_idx      = lv_m1[IDXW-1:0];
  assign depth_idx   = IDXW'(depth_q - 1'b1);
  assign k           = path_q[lv_idx];
  assign child_shift = LVW'(MAX_DEPTH - 1) - lv_q;

  assign status_o.walk_empty = (lv_q == '0);
  assign status_o.path_end   = (k == ovpf_pkg::CHILD_COUNT);

  // Walk control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q     <= '0;
      path_q   <= '{default: '0};
      frac_q   <= '0;
      err_q    <= '0;
      capped_q <= 1'b0;
    end else if (cmd_i.sum) begin
      lv_q     <= '0;
      path_q   <= '{default: '0};
      frac_q   <= '0;
      err_q    <= '0;
      capped_q <= 1'b0;
    end else if (cmd_i.eval) begin
      if (all_in) begin
        frac_q <= frac_q + vol;
      end else if (!none_in) begin
        if (below || at_cap) begin
          if (!below) capped_q <= 1'b1;
          frac_q <= frac_q + (vol >> 1);
          err_q  <= err_q + (vol >> 1);
        end else begin
          path_q[depth_idx] <= '0;
          lv_q              <= depth_q;
        end
      end
    end else if (cmd_i.next && !status_o.walk_empty) begin
      if (status_o.path_end) lv_q <= lv_m1;
      else path_q[lv_idx] <= k + 1'b1;
    end
  end

  // Cell origin dot product and the stack of split cells
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      cell_d0_q <= (DOT_W'(pd_q[0]) + DOT_W'(pd_q[1]) + DOT_W'(pd_q[2]))
                   <<< (MAX_DEPTH - 1);
      depth_q   <= LVW'(1);
    end else if (cmd_i.eval) begin
      if (!all_in && !none_in && !below && !at_cap) stack_q[depth_idx] <= cell_d0_q;
    end else if (cmd_i.next && !status_o.walk_empty && !status_o.path_end) begin
      cell_d0_q <= stack_q[lv_idx] + (sub_q[k[2:0]] <<< child_shift);
      depth_q   <= lv_q + 1'b1;
    end
  end

  // Result register, saturated to the field
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      frac_out_q   <= (CMP_W'(frac_q) > CMP_W'(FIELD_MAX)) ? FIELD_MAX
                                                            : ovpf_pkg::FIELD_W'(frac_q);
      err_out_q    <= (CMP_W'(err_q) > CMP_W'(FIELD_MAX)) ? FIELD_MAX
                                                           : ovpf_pkg::FIELD_W'(err_q);
      capped_out_q <= capped_q;
    end
  end

  assign inside_fraction_o = frac_out_q;
  assign error_bound_o     = err_out_q;
  assign depth_capped_o    = capped_out_q;

endmodule

// ----- rtl/octree_voxel_plane_fraction.sv -----
// From transfer in, a voxel passes the multiply and sum set-up steps, then an evaluate and a next
// step per octree cell tested, with an extra next step per split cell, and waits for a full output register to drain.
// One voxel is walked at a time; the next is taken the cycle after its result is
// registered, while that result waits in the output register.
// Reset (rst_ni low, asynchronous) clears the walk, drops the output valid and restores
// the accuracy threshold to 1678.
module octree_voxel_plane_fraction #(
  parameter int unsigned MAX_DEPTH     = ovpf_pkg::MAX_DEPTH_DEF,
  parameter int unsigned FRACTION_BITS = ovpf_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [ovpf_pkg::ADDR_W-1:0]  paddr,
  input  logic        [ovpf_pkg::DATA_W-1:0]  pwdata,
  output logic        [ovpf_pkg::DATA_W-1:0]  prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ovpf_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] origin_y_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] origin_z_i,
  input  logic        [ovpf_pkg::SIZE_W-1:0]  size_x_i,
  input  logic        [ovpf_pkg::SIZE_W-1:0]  size_y_i,
  input  logic        [ovpf_pkg::SIZE_W-1:0]  size_z_i,
  input  logic signed [ovpf_pkg::NORM_W-1:0]  normal_x_i,
  input  logic signed [ovpf_pkg::NORM_W-1:0]  normal_y_i,
  input  logic signed [ovpf_pkg::NORM_W-1:0]  normal_z_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] vertex_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic        [ovpf_pkg::FIELD_W-1:0] inside_fraction_o,
  output logic        [ovpf_pkg::FIELD_W-1:0] error_bound_o,
  output logic                                depth_capped_o
);

  logic [ovpf_pkg::FIELD_W-1:0] threshold_q;
  logic                         thr_sel;
  ovpf_pkg::cmd_t               cmd;
  ovpf_pkg::status_t            status;

  // Register write on the access phase; the low address bits are ignored
  assign pready  = 1'b1;
  assign thr_sel = (paddr[ovpf_pkg::ADDR_W-1:2]
                    == ovpf_pkg::ADDR_THRESHOLD[ovpf_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ovpf_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && thr_sel) begin
      threshold_q <= pwdata[ovpf_pkg::FIELD_W-1:0];
    end
  end

  assign prdata = thr_sel ? ovpf_pkg::DATA_W'(threshold_q) : '0;

  ovpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ovpf_datapath #(
    .MAX_DEPTH    (MAX_DEPTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .threshold_i      (threshold_q),
    .origin_x_i       (origin_x_i),
    .origin_y_i       (origin_y_i),
    .origin_z_i       (origin_z_i),
    .size_x_i         (size_x_i),
    .size_y_i         (size_y_i),
    .size_z_i         (size_z_i),
    .normal_x_i       (normal_x_i),
    .normal_y_i       (normal_y_i),
    .normal_z_i       (normal_z_i),
    .vertex_x_i       (vertex_x_i),
    .vertex_y_i       (vertex_y_i),
    .vertex_z_i       (vertex_z_i),
    .inside_fraction_o(inside_fraction_o),
    .error_bound_o    (error_bound_o),
    .depth_capped_o   (depth_capped_o)
  );

endmodule

// ----- rtl/ovpf_checker.sv -----
module ovpf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [ovpf_pkg::FIELD_W-1:0]       inside_fraction_o,
  input logic [ovpf_pkg::FIELD_W-1:0]       error_bound_o,
  input logic                               depth_capped_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(inside_fraction_o)
      && $stable(error_bound_o) && $stable(depth_capped_o))
    else $error("result changed while stalled");

  // Half-counted cells are part of the fraction, so the bound never exceeds it
  a_err_le_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_bound_o <= inside_fraction_o)
    else $error("error bound exceeds inside fraction");

  // A transfer in starts a walk, so the block is busy next cycle
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a voxel is in flight");

endmodule

bind octree_voxel_plane_fraction ovpf_checker u_ovpf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .inside_fraction_o(inside_fraction_o),
  .error_bound_o    (error_bound_o),
  .depth_capped_o   (depth_capped_o)
);

// ----- tb/ovpf_checker.sv -----
`timescale 1ns / 100ps

module ovpf_predictor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic        [ovpf_pkg::ADDR_W-1:0]  paddr,
  input  logic        [ovpf_pkg::DATA_W-1:0]  pwdata,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic signed [ovpf_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] origin_y_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] origin_z_i,
  input  logic        [ovpf_pkg::SIZE_W-1:0]  size_x_i,
  input  logic        [ovpf_pkg::SIZE_W-1:0]  size_y_i,
  input  logic        [ovpf_pkg::SIZE_W-1:0]  size_z_i,
  input  logic signed [ovpf_pkg::NORM_W-1:0]  normal_x_i,
  input  logic signed [ovpf_pkg::NORM_W-1:0]  normal_y_i,
  input  logic signed [ovpf_pkg::NORM_W-1:0]  normal_z_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [ovpf_pkg::COORD_W-1:0] vertex_z_i,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic        [ovpf_pkg::FIELD_W-1:0] inside_fraction_o,
  input  logic        [ovpf_pkg::FIELD_W-1:0] error_bound_o,
  input  logic                                depth_capped_o,
  output int                                  mismatch_count_o,
  output int                                  pending_results_o
);
  import ovpf_pkg::*;

  localparam int MD = MAX_DEPTH_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam longint FIELD_MAX = (64'sd1 << FIELD_W) - 1;

  typedef struct packed {
    logic [FIELD_W-1:0] fraction;
    logic [FIELD_W-1:0] error;
    logic               capped;
  } plane_result_t;

  plane_result_t  fraction_queue[$];
  logic [FIELD_W-1:0] threshold;
  int             mismatches;

  // walk state of the predictor
  longint rel_d[3];
  longint nrm_c[3];
  longint sz_c[3];
  longint frac_sum;
  longint err_sum;
  bit     cap_seen;

  function automatic longint cell_volume(int depth);
    int sh;
    sh = FB - 3 * (depth - 1);
    return (sh < 0) ? 64'sd0 : (64'sd1 << sh);
  endfunction

  // Classify one cell by its corners and book its volume; 1 means split it
  function automatic bit classify_cell(int depth, longint ox, longint oy, longint oz);
    longint cs[3];
    longint off[3];
    longint p;
    longint dot;
    longint vol;
    int     corners_in;
    off[0] = ox;
    off[1] = oy;
    off[2] = oz;
    corners_in = 0;
    for (int i = 0; i < 3; i++) cs[i] = sz_c[i] << (MD - depth);
    for (int c = 0; c < 8; c++) begin
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        p = rel_d[i] + off[i] + (((c >> i) & 1) ? cs[i] : 64'sd0);
        dot += nrm_c[i] * p;
      end
      if (dot < 0) corners_in++;
    end
    vol = cell_volume(depth);
    if (corners_in == 8) begin
      frac_sum += vol;
      return 1'b0;
    end
    if (corners_in == 0) return 1'b0;
    if (vol < longint'(threshold) || depth >= MD) begin
      if (!(vol < longint'(threshold))) cap_seen = 1'b1;
      frac_sum += vol >>> 1;
      err_sum  += vol >>> 1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Walk the octree depth first and return the expected result
  function automatic plane_result_t predict_fraction();
    longint        offs[MD][3];
    int            path[MD];
    int            lvl;
    int            lv;
    int            k;
    longint        cx;
    longint        cy;
    longint        cz;
    plane_result_t r;
    rel_d[0] = (longint'(origin_x_i) - longint'(vertex_x_i)) <<< (MD - 1);
    rel_d[1] = (longint'(origin_y_i) - longint'(vertex_y_i)) <<< (MD - 1);
    rel_d[2] = (longint'(origin_z_i) - longint'(vertex_z_i)) <<< (MD - 1);
    nrm_c[0] = longint'(normal_x_i);
    nrm_c[1] = longint'(normal_y_i);
    nrm_c[2] = longint'(normal_z_i);
    sz_c[0]  = longint'({1'b0, size_x_i});
    sz_c[1]  = longint'({1'b0, size_y_i});
    sz_c[2]  = longint'({1'b0, size_z_i});
    frac_sum = 0;
    err_sum  = 0;
    cap_seen = 1'b0;
    lvl      = 0;
    for (int i = 0; i < MD; i++) path[i] = 0;
    if (classify_cell(1, 0, 0, 0)) begin
      for (int i = 0; i < 3; i++) offs[0][i] = 0;
      lvl = 1;
    end
    while (lvl > 0) begin
      lv = lvl;
      k  = path[lv-1];
      if (k >= 8) begin
        lvl--;
      end else begin
        path[lv-1] = k + 1;
        cx = offs[lv-1][0] + (k[0] ? (sz_c[0] << (MD - 1 - lv)) : 64'sd0);
        cy = offs[lv-1][1] + (k[1] ? (sz_c[1] << (MD - 1 - lv)) : 64'sd0);
        cz = offs[lv-1][2] + (k[2] ? (sz_c[2] << (MD - 1 - lv)) : 64'sd0);
        if (classify_cell(lv + 1, cx, cy, cz) && lv < MD) begin
          offs[lv][0] = cx;
          offs[lv][1] = cy;
          offs[lv][2] = cz;
          path[lv]    = 0;
          lvl         = lv + 1;
        end
      end
    end
    if (frac_sum > FIELD_MAX) frac_sum = FIELD_MAX;
    if (err_sum > FIELD_MAX) err_sum = FIELD_MAX;
    r.fraction = frac_sum[FIELD_W-1:0];
    r.error    = err_sum[FIELD_W-1:0];
    r.capped   = cap_seen;
    return r;
  endfunction

  // Track the threshold, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    plane_result_t exp_r;
    if (!rst_ni) begin
      fraction_queue.delete();
      threshold         = THRESHOLD_RESET;
      mismatches        = 0;
      mismatch_count_o  <= 0;
      pending_results_o <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (fraction_queue.size() == 0) begin
          $display("%0t: unexpected result frac=%0d err=%0d capped=%0b", $time,
                   inside_fraction_o, error_bound_o, depth_capped_o);
          mismatches++;
        end else begin
          exp_r = fraction_queue.pop_front();
          if (inside_fraction_o !== exp_r.fraction) begin
            $display("%0t: inside_fraction expected %0d actual %0d", $time,
                     exp_r.fraction, inside_fraction_o);
            mismatches++;
          end
          if (error_bound_o !== exp_r.error) begin
            $display("%0t: error_bound expected %0d actual %0d", $time,
                     exp_r.error, error_bound_o);
            mismatches++;
          end
          if (depth_capped_o !== exp_r.capped) begin
            $display("%0t: depth_capped expected %0b actual %0b", $time,
                     exp_r.capped, depth_capped_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) fraction_queue.push_back(predict_fraction());
      if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD)
        threshold = pwdata[FIELD_W-1:0];
      mismatch_count_o  <= mismatches;
      pending_results_o <= fraction_queue.size();
    end
  end

endmodule

// ----- tb/tb_octree_voxel_plane_fraction.sv -----
`timescale 1ns / 100ps

module tb_octree_voxel_plane_fraction;
  import ovpf_pkg::*;

  typedef struct {
    int ox, oy, oz;
    int sx, sy, sz;
    int nx, ny, nz;
    int vx, vy, vz;
  } voxel_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [COORD_W-1:0] origin_x_i, origin_y_i, origin_z_i;
  logic [SIZE_W-1:0] size_x_i, size_y_i, size_z_i;
  logic signed [NORM_W-1:0] normal_x_i, normal_y_i, normal_z_i;
  logic signed [COORD_W-1:0] vertex_x_i, vertex_y_i, vertex_z_i;
  logic [FIELD_W-1:0] inside_fraction_o, error_bound_o;
  logic depth_capped_o;
  int   mismatch_count;
  int   pending_results;
  bit   calm;

  localparam int ONE = 65536;
  localparam int CMIN = -(1 << 27);
  localparam int CMAX = (1 << 27) - 1;
  localparam int SMAX = 1 << 20;

  octree_voxel_plane_fraction dut (.*);

  ovpf_predictor fraction_check (
    .mismatch_count_o  (mismatch_count),
    .pending_results_o (pending_results),
    .*
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Stall the result side at random except in calm stretches
  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 17);

  initial begin
    #50_000_000;
    $display("[octree_voxel_plane_fraction] ERROR");
    $finish;
  end

  task automatic write_threshold(int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_THRESHOLD;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold valid across back-to-back transfers; drop it only for an idle gap
  task automatic send_voxel(voxel_t v);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= COORD_W'(v.ox);
    origin_y_i <= COORD_W'(v.oy);
    origin_z_i <= COORD_W'(v.oz);
    size_x_i   <= SIZE_W'(v.sx);
    size_y_i   <= SIZE_W'(v.sy);
    size_z_i   <= SIZE_W'(v.sz);
    normal_x_i <= NORM_W'(v.nx);
    normal_y_i <= NORM_W'(v.ny);
    normal_z_i <= NORM_W'(v.nz);
    vertex_x_i <= COORD_W'(v.vx);
    vertex_y_i <= COORD_W'(v.vy);
    vertex_z_i <= COORD_W'(v.vz);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Lower valid and wait until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic voxel_t mk(int ox, int oy, int oz, int sx, int sy, int sz,
                                int nx, int ny, int nz, int vx, int vy, int vz);
    voxel_t v;
    v = '{ox, oy, oz, sx, sy, sz, nx, ny, nz, vx, vy, vz};
    return v;
  endfunction

  function automatic int rand_norm();
    return $urandom_range(2 * ONE) - ONE;
  endfunction

  function automatic int rand_size();
    case ($urandom_range(3))
      0:       return SMAX;
      1:       return $urandom_range(1, 64);
      default: return $urandom_range(1, SMAX);
    endcase
  endfunction

  // Mostly a plane through the voxel, some degenerate normals, some noise
  function automatic voxel_t rand_voxel();
    voxel_t v;
    int     kind;
    kind = $urandom_range(99);
    v.sx = rand_size();
    v.sy = rand_size();
    v.sz = rand_size();
    v.nx = rand_norm();
    v.ny = rand_norm();
    v.nz = rand_norm();
    if (kind < 85) begin
      v.ox = $urandom_range(1 << 27) - (1 << 26);
      v.oy = $urandom_range(1 << 27) - (1 << 26);
      v.oz = $urandom_range(1 << 27) - (1 << 26);
      v.vx = v.ox + $urandom_range(v.sx);
      v.vy = v.oy + $urandom_range(v.sy);
      v.vz = v.oz + $urandom_range(v.sz);
      if (kind >= 70) begin
        if ($urandom_range(1)) v.nx = 0;
        if ($urandom_range(1)) v.ny = 0;
        if ($urandom_range(1)) v.nz = 0;
      end
    end else begin
      v.ox = $signed($urandom() << 4) >>> 4;
      v.oy = $signed($urandom() << 4) >>> 4;
      v.oz = $signed($urandom() << 4) >>> 4;
      v.vx = $signed($urandom() << 4) >>> 4;
      v.vy = $signed($urandom() << 4) >>> 4;
      v.vz = $signed($urandom() << 4) >>> 4;
    end
    return v;
  endfunction

  initial begin
    int unsigned rand_thresholds[6];
    int          chunk_items[6];
    calm        = 1'b0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    origin_x_i  = '0;
    origin_y_i  = '0;
    origin_z_i  = '0;
    size_x_i    = '0;
    size_y_i    = '0;
    size_z_i    = '0;
    normal_x_i  = '0;
    normal_y_i  = '0;
    normal_z_i  = '0;
    vertex_x_i  = '0;
    vertex_y_i  = '0;
    vertex_z_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed voxels at the reset threshold
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, ONE, 0, 0, ONE / 2, 0, 0));
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, ONE, 0, 0, 2 * ONE, 0, 0));
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, ONE, 0, 0, -100, 0, 0));
    send_voxel(mk(5, 6, 7, ONE, ONE, ONE, 0, 0, 0, 100, 100, 100));
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, -ONE, ONE, ONE, ONE / 2, ONE / 2, ONE / 2));
    send_voxel(mk(CMIN, CMIN, CMIN, SMAX, SMAX, SMAX, ONE, ONE, ONE, CMAX, CMAX, CMAX));
    send_voxel(mk(CMAX, CMAX, CMAX, SMAX, SMAX, SMAX, -ONE, -ONE, -ONE,
                  CMIN, CMIN, CMIN));
    send_voxel(mk(CMIN, CMAX, 0, SMAX, SMAX, SMAX, ONE, -ONE, ONE,
                  CMIN + SMAX / 3, CMAX + SMAX / 2, SMAX / 5));
    send_voxel(mk(0, 0, 0, 1, 1, 1, 1, 1, 1, 0, 0, 0));
    send_voxel(mk(0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1));
    send_voxel(mk(0, 0, 0, 0, ONE, ONE, ONE, ONE, 0, 10, ONE / 3, 0));
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, 0, 0, ONE, 0, 0, ONE / 4));
    send_voxel(mk(-ONE, -ONE, -ONE, SMAX, 1, SMAX, ONE, -ONE, 7, 3, 0, -5));
    drain();

    // Zero threshold: split straddling cells down to the depth limit
    write_threshold(0);
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, ONE, 0, 0, ONE / 3, 0, 0));
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, ONE, ONE / 2, -ONE / 3, ONE / 2, ONE / 3, ONE / 5));
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
    drain();

    // Threshold at the leaf volume: capped leaves still appear
    write_threshold(8);
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, 0, ONE, 0, 0, ONE / 7, 0));
    drain();

    // Threshold at the root volume: a straddling root still splits, its straddling children count half
    write_threshold(1 << 24);
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, ONE, 0, 0, ONE / 2, 0, 0));
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, ONE, 0, 0, 2 * ONE, 0, 0));
    send_voxel(mk(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, ONE, 9, 9, 9));
    drain();

    // Random chunks at a spread of thresholds
    rand_thresholds = '{262145, 32769, 4097, 1 << 24, 2097153, 0};
    chunk_items     = '{300, 350, 100, 250, 300, 200};
    rand_thresholds[5] = $urandom_range(32769, 1 << 24);
    for (int ch = 0; ch < 6; ch++) begin
      write_threshold(rand_thresholds[ch]);
      for (int n = 0; n < chunk_items[ch]; n++) begin
        calm = (ch == 1) && (n >= 100) && (n < 250);
        send_voxel(rand_voxel());
      end
      calm = 1'b0;
      drain();
    end
    write_threshold(THRESHOLD_RESET);
    for (int n = 0; n < 20; n++) send_voxel(rand_voxel());
    drain();

    if (mismatch_count == 0) begin
      $display("[octree_voxel_plane_fraction] OK");
    end else begin
      $display("[octree_voxel_plane_fraction] ERROR");
    end
    $finish;
  end

endmodule
